// ===== rtl/tdcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tdcc_pkg
// Shared types, constants and helper functions of the trading-day calendar
// check block.
// ----------------------------------------------------------------------------
package tdcc_pkg;

    localparam int unsigned NumStages = 13;
    localparam int unsigned LastStage = NumStages - 1;
    localparam int unsigned TapStage  = NumStages - 2;

    localparam int unsigned YearW   = 14;
    localparam int unsigned MonthW  = 4;
    localparam int unsigned DayW    = 5;
    localparam int unsigned MinuteW = 11;
    localparam int unsigned DowW    = 3;
    localparam int unsigned CfgW    = 11;
    localparam int unsigned CfgIdxW = 1;

    localparam logic [CfgIdxW-1:0] RegOpen  = 1'd0;
    localparam logic [CfgIdxW-1:0] RegClose = 1'd1;

    localparam logic [CfgW-1:0] OpenReset  = 11'(9 * 60 + 30);
    localparam logic [CfgW-1:0] CloseReset = 11'(16 * 60);

    localparam logic [MonthW-1:0] MonJan = 4'd1;
    localparam logic [MonthW-1:0] MonFeb = 4'd2;
    localparam logic [MonthW-1:0] MonMar = 4'd3;
    localparam logic [MonthW-1:0] MonApr = 4'd4;
    localparam logic [MonthW-1:0] MonMay = 4'd5;
    localparam logic [MonthW-1:0] MonJun = 4'd6;
    localparam logic [MonthW-1:0] MonJul = 4'd7;
    localparam logic [MonthW-1:0] MonAug = 4'd8;
    localparam logic [MonthW-1:0] MonSep = 4'd9;
    localparam logic [MonthW-1:0] MonOct = 4'd10;
    localparam logic [MonthW-1:0] MonNov = 4'd11;
    localparam logic [MonthW-1:0] MonDec = 4'd12;

    localparam logic [DowW-1:0] DowMon = 3'd0;
    localparam logic [DowW-1:0] DowThu = 3'd3;
    localparam logic [DowW-1:0] DowFri = 3'd4;
    localparam logic [DowW-1:0] DowSun = 3'd6;

    // reciprocal constants, exact floor for every operand used here
    localparam int unsigned RecipShift = 24;
    localparam logic [24:0] Recip3   = 25'((2**RecipShift + 3 - 1) / 3);
    localparam logic [24:0] Recip7   = 25'((2**RecipShift + 7 - 1) / 7);
    localparam logic [24:0] Recip19  = 25'((2**RecipShift + 19 - 1) / 19);
    localparam logic [24:0] Recip25  = 25'((2**RecipShift + 25 - 1) / 25);
    localparam logic [24:0] Recip30  = 25'((2**RecipShift + 30 - 1) / 30);
    localparam logic [24:0] Recip31  = 25'((2**RecipShift + 31 - 1) / 31);
    localparam logic [24:0] Recip100 = 25'((2**RecipShift + 100 - 1) / 100);
    localparam logic [24:0] Recip451 = 25'((2**RecipShift + 451 - 1) / 451);

    typedef struct packed {
        logic               valid;
        logic [MonthW-1:0]  month;
        logic [DayW-1:0]    day;
        logic [MinuteW-1:0] minute;
        logic [DowW-1:0]    dow;
    } t_date_info;

    typedef struct packed {
        logic            date_valid;
        logic [DowW-1:0] day_of_week;
        logic            is_holiday;
        logic            is_trading_day;
        logic            market_open;
    } t_result;

    function automatic logic [15:0] recip_div(input logic [15:0] x, input logic [24:0] recip);
        logic [40:0] p;
        p = 41'(x) * 41'(recip);
        return p[39:24];
    endfunction

    function automatic logic [2:0] sak(input logic [MonthW-1:0] m);
        logic [2:0] v;
        unique case (m)
            MonJan:  v = 3'd0;
            MonFeb:  v = 3'd3;
            MonMar:  v = 3'd2;
            MonApr:  v = 3'd5;
            MonMay:  v = 3'd0;
            MonJun:  v = 3'd3;
            MonJul:  v = 3'd5;
            MonAug:  v = 3'd1;
            MonSep:  v = 3'd4;
            MonOct:  v = 3'd6;
            MonNov:  v = 3'd2;
            MonDec:  v = 3'd4;
            default: v = 3'd0;
        endcase
        return v;
    endfunction

    function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m, input logic leap);
        logic [DayW-1:0] v;
        unique case (m)
            MonFeb:                         v = leap ? 5'd29 : 5'd28;
            MonApr, MonJun, MonSep, MonNov: v = 5'd30;
            default:                        v = 5'd31;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/tdcc_in_if.sv =====
// ----------------------------------------------------------------------------
// tdcc_in_if
// Input channel: one local date and minute of day per transfer.
// ----------------------------------------------------------------------------
interface tdcc_in_if;
    logic                             valid;
    logic                             ready;
    logic [tdcc_pkg::YearW-1:0]       year;
    logic [tdcc_pkg::MonthW-1:0]      month;
    logic [tdcc_pkg::DayW-1:0]        day_of_month;
    logic [tdcc_pkg::MinuteW-1:0]     minute_of_day;

    modport source(output valid, year, month, day_of_month, minute_of_day, input ready);
    modport sink(input valid, year, month, day_of_month, minute_of_day, output ready);
endinterface

// ===== rtl/tdcc_out_if.sv =====
// ----------------------------------------------------------------------------
// tdcc_out_if
// Result channel: date classification flags per transfer.
// ----------------------------------------------------------------------------
interface tdcc_out_if;
    logic                        valid;
    logic                        ready;
    logic                        date_valid;
    logic [tdcc_pkg::DowW-1:0]   day_of_week;
    logic                        is_holiday;
    logic                        is_trading_day;
    logic                        market_open;

    modport source(output valid, date_valid, day_of_week, is_holiday, is_trading_day,
                   market_open, input ready);
    modport sink(input valid, date_valid, day_of_week, is_holiday, is_trading_day,
                 market_open, output ready);
endinterface

// ===== rtl/tdcc_easter.sv =====
// ----------------------------------------------------------------------------
// tdcc_easter
// Pipelined anonymous Gregorian computus, yields the Good Friday month and
// day at stage TapStage. Divisions use constant-reciprocal multiplies.
// ----------------------------------------------------------------------------
module tdcc_easter (
    input  logic                          i_clk,
    input  logic                          i_adv,
    input  logic [tdcc_pkg::YearW-1:0]    i_year,
    output logic [tdcc_pkg::MonthW-1:0]   o_gf_month,
    output logic [tdcc_pkg::DayW-1:0]     o_gf_day
);

    logic [13:0] r0_y;
    logic [9:0]  r0_q19;
    logic [7:0]  r0_q100;
    logic [4:0]  r1_a, r2_a, r3_a, r4_a, r5_a, r6_a;
    logic [7:0]  r1_b, r2_b, r3_b, r4_b;
    logic [6:0]  r1_c, r2_c, r3_c, r4_c;
    logic [2:0]  r1_f;
    logic [5:0]  r2_g;
    logic [12:0] r3_hs, r4_hs;
    logic [7:0]  r4_hq;
    logic [4:0]  r5_h, r6_h, r7_h, r8_h;
    logic [6:0]  r5_ls, r6_ls;
    logic [3:0]  r6_lq;
    logic [2:0]  r7_l, r8_l;
    logic [8:0]  r7_ms;
    logic        r8_mq;
    logic [7:0]  r9_s, r10_s;
    logic [2:0]  r10_em;
    logic [3:0]  r11_gm;
    logic [4:0]  r11_gd;

    logic [4:0]  n1_a;
    logic [6:0]  n1_c;
    logic [12:0] n3_hs;
    logic [4:0]  n5_h;
    logic [6:0]  n5_ls;
    logic [2:0]  n7_l;
    logic [8:0]  n7_ms;
    logic [7:0]  n9_s;
    logic [4:0]  n11_ed;
    logic [3:0]  n11_gm;
    logic [4:0]  n11_gd;

    always_comb begin
        n1_a  = 5'(r0_y - 14'(r0_q19) * 14'd19);
        n1_c  = 7'(r0_y - 14'(r0_q100) * 14'd100);
        n3_hs = 13'(r2_a) * 13'd19 + 13'(r2_b) + 13'd15 + 13'(30 * 200)
              - 13'(r2_b[7:2]) - 13'(r2_g);
        n5_h  = 5'(r4_hs - 13'(r4_hq) * 13'd30);
        n5_ls = 7'd32 + 7'({r4_b[1:0], 1'b0}) + 7'({r4_c[6:2], 1'b0})
              - 7'(n5_h) - 7'(r4_c[1:0]);
        n7_l  = 3'(r6_ls - 7'(r6_lq) * 7'd7);
        n7_ms = 9'(r6_a) + 9'(r6_h) * 9'd11 + 9'(n7_l) * 9'd22;
        n9_s  = 8'(r8_h) + 8'(r8_l) + 8'd114 - (r8_mq ? 8'd7 : 8'd0);
        n11_ed = 5'(r10_s - 8'(r10_em) * 8'd31) + 5'd1;
        // Easter on the 1st or 2nd puts Good Friday in the prior month
        if (n11_ed > 5'd2) begin
            n11_gm = 4'(r10_em);
            n11_gd = n11_ed - 5'd2;
        end else begin
            n11_gm = 4'(r10_em) - 4'd1;
            n11_gd = 5'd29 + n11_ed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r0_y    <= i_year;
            r0_q19  <= 10'(tdcc_pkg::recip_div(16'(i_year), tdcc_pkg::Recip19));
            r0_q100 <= 8'(tdcc_pkg::recip_div(16'(i_year), tdcc_pkg::Recip100));

            r1_a <= n1_a;
            r1_b <= r0_q100;
            r1_c <= n1_c;
            r1_f <= 3'(tdcc_pkg::recip_div(16'(r0_q100) + 16'd8, tdcc_pkg::Recip25));

            r2_a <= r1_a;
            r2_b <= r1_b;
            r2_c <= r1_c;
            r2_g <= 6'(tdcc_pkg::recip_div(16'(r1_b) - 16'(r1_f) + 16'd1, tdcc_pkg::Recip3));

            r3_a  <= r2_a;
            r3_b  <= r2_b;
            r3_c  <= r2_c;
            r3_hs <= n3_hs;

            r4_a  <= r3_a;
            r4_b  <= r3_b;
            r4_c  <= r3_c;
            r4_hs <= r3_hs;
            r4_hq <= 8'(tdcc_pkg::recip_div(16'(r3_hs), tdcc_pkg::Recip30));

            r5_a  <= r4_a;
            r5_h  <= n5_h;
            r5_ls <= n5_ls;

            r6_a  <= r5_a;
            r6_h  <= r5_h;
            r6_ls <= r5_ls;
            r6_lq <= 4'(tdcc_pkg::recip_div(16'(r5_ls), tdcc_pkg::Recip7));

            r7_h  <= r6_h;
            r7_l  <= n7_l;
            r7_ms <= n7_ms;

            r8_h  <= r7_h;
            r8_l  <= r7_l;
            r8_mq <= 1'(tdcc_pkg::recip_div(16'(r7_ms), tdcc_pkg::Recip451));

            r9_s <= n9_s;

            r10_s  <= r9_s;
            r10_em <= 3'(tdcc_pkg::recip_div(16'(r9_s), tdcc_pkg::Recip31));

            r11_gm <= n11_gm;
            r11_gd <= n11_gd;
        end
    end

    assign o_gf_month = r11_gm;
    assign o_gf_day   = r11_gd;

endmodule

// ===== rtl/tdcc_date.sv =====
// ----------------------------------------------------------------------------
// tdcc_date
// Date validity and weekday pipeline, delayed to line up with the computus.
// ----------------------------------------------------------------------------
module tdcc_date (
    input  logic                          i_clk,
    input  logic                          i_adv,
    input  logic [tdcc_pkg::YearW-1:0]    i_year,
    input  logic [tdcc_pkg::MonthW-1:0]   i_month,
    input  logic [tdcc_pkg::DayW-1:0]     i_day,
    input  logic [tdcc_pkg::MinuteW-1:0]  i_minute,
    output tdcc_pkg::t_date_info          o_info
);

    logic [13:0] r0_y;
    logic [3:0]  r0_m, r1_m, r2_m;
    logic [4:0]  r0_d, r1_d, r2_d;
    logic [10:0] r0_t, r1_t, r2_t;
    logic [14:0] r0_yy;
    logic [7:0]  r0_qyy;
    logic [7:0]  r0_qy;
    logic        r1_ok, r2_ok;
    logic [14:0] r1_ws, r2_ws;
    logic [11:0] r2_wq;

    logic [14:0] n0_yy;
    logic        n1_cent;
    logic        n1_leap;
    logic        n1_ok;
    logic [14:0] n1_ws;
    logic [2:0]  n3_w;
    tdcc_pkg::t_date_info n3_info;

    tdcc_pkg::t_date_info r_tap [3:tdcc_pkg::TapStage];

    always_comb begin
        // year shifted by 400 keeps the weekday sum non-negative
        n0_yy   = 15'(i_year) + 15'd400 - ((i_month < tdcc_pkg::MonMar) ? 15'd1 : 15'd0);
        n1_cent = (r0_y - 14'(r0_qy) * 14'd100) == 14'd0;
        n1_leap = (r0_y[1:0] == 2'd0 && !n1_cent) || (n1_cent && r0_qy[1:0] == 2'd0);
        n1_ok   = r0_m >= tdcc_pkg::MonJan && r0_m <= tdcc_pkg::MonDec && r0_d != 5'd0
                  && r0_d <= tdcc_pkg::month_len(r0_m, n1_leap);
        n1_ws   = r0_yy + 15'(r0_yy[14:2]) - 15'(r0_qyy) + 15'(r0_qyy[7:2])
                  + 15'(tdcc_pkg::sak(r0_m)) + 15'(r0_d);
        n3_w    = 3'(r2_ws - 15'(r2_wq) * 15'd7);
        n3_info.valid  = r2_ok;
        n3_info.month  = r2_m;
        n3_info.day    = r2_d;
        n3_info.minute = r2_t;
        // sum counts from Sunday; shift to Monday first
        n3_info.dow    = (n3_w == 3'd0) ? tdcc_pkg::DowSun : n3_w - 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r0_y   <= i_year;
            r0_m   <= i_month;
            r0_d   <= i_day;
            r0_t   <= i_minute;
            r0_yy  <= n0_yy;
            r0_qyy <= 8'(tdcc_pkg::recip_div(16'(n0_yy), tdcc_pkg::Recip100));
            r0_qy  <= 8'(tdcc_pkg::recip_div(16'(i_year), tdcc_pkg::Recip100));

            r1_m  <= r0_m;
            r1_d  <= r0_d;
            r1_t  <= r0_t;
            r1_ok <= n1_ok;
            r1_ws <= n1_ws;

            r2_m  <= r1_m;
            r2_d  <= r1_d;
            r2_t  <= r1_t;
            r2_ok <= r1_ok;
            r2_ws <= r1_ws;
            r2_wq <= 12'(tdcc_pkg::recip_div(16'(r1_ws), tdcc_pkg::Recip7));

            r_tap[3] <= n3_info;
        end
    end

    for (genvar k = 4; k <= tdcc_pkg::TapStage; k++) begin : g_tap
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_info = r_tap[tdcc_pkg::TapStage];

endmodule

// ===== rtl/tdcc_classify.sv =====
// ----------------------------------------------------------------------------
// tdcc_classify
// Final stage: holiday rules, trading day and session window check.
// ----------------------------------------------------------------------------
module tdcc_classify (
    input  logic                          i_clk,
    input  logic                          i_adv,
    input  tdcc_pkg::t_date_info          i_info,
    input  logic [tdcc_pkg::MonthW-1:0]   i_gf_month,
    input  logic [tdcc_pkg::DayW-1:0]     i_gf_day,
    input  logic [tdcc_pkg::CfgW-1:0]     i_open,
    input  logic [tdcc_pkg::CfgW-1:0]     i_close,
    output tdcc_pkg::t_result             o_res
);

    tdcc_pkg::t_result r_res;
    tdcc_pkg::t_result n_res;

    function automatic logic observed(input logic [3:0] m, input logic [4:0] d,
                                      input logic [2:0] w, input logic [3:0] hm,
                                      input logic [4:0] hd);
        logic hit;
        hit = (d == hd && w <= tdcc_pkg::DowFri)
           || (d + 5'd1 == hd && w == tdcc_pkg::DowFri)
           || (d == hd + 5'd1 && w == tdcc_pkg::DowMon);
        return m == hm && hit;
    endfunction

    function automatic logic nth_dow(input logic [3:0] m, input logic [4:0] d,
                                     input logic [2:0] w, input logic [3:0] hm,
                                     input logic [2:0] hw, input logic [4:0] lo);
        return m == hm && w == hw && d >= lo && d <= lo + 5'd6;
    endfunction

    always_comb begin
        logic [3:0] m;
        logic [4:0] d;
        logic [2:0] w;
        logic       hol;
        logic       trade;
        m = i_info.month;
        d = i_info.day;
        w = i_info.dow;
        hol = (m == tdcc_pkg::MonDec && d == 5'd31 && w == tdcc_pkg::DowFri)
           || observed(m, d, w, tdcc_pkg::MonJan, 5'd1)
           || nth_dow(m, d, w, tdcc_pkg::MonJan, tdcc_pkg::DowMon, 5'd15)
           || nth_dow(m, d, w, tdcc_pkg::MonFeb, tdcc_pkg::DowMon, 5'd15)
           || (m == i_gf_month && d == i_gf_day)
           || (m == tdcc_pkg::MonMay && w == tdcc_pkg::DowMon && d > 5'd24)
           || observed(m, d, w, tdcc_pkg::MonJun, 5'd19)
           || observed(m, d, w, tdcc_pkg::MonJul, 5'd4)
           || nth_dow(m, d, w, tdcc_pkg::MonSep, tdcc_pkg::DowMon, 5'd1)
           || nth_dow(m, d, w, tdcc_pkg::MonNov, tdcc_pkg::DowThu, 5'd22)
           || observed(m, d, w, tdcc_pkg::MonDec, 5'd25);
        trade = w <= tdcc_pkg::DowFri && !hol;
        // invalid date clears every flag
        n_res.date_valid     = i_info.valid;
        n_res.day_of_week    = i_info.valid ? w : 3'd0;
        n_res.is_holiday     = i_info.valid && hol;
        n_res.is_trading_day = i_info.valid && trade;
        n_res.market_open    = i_info.valid && trade
                               && i_info.minute >= i_open && i_info.minute < i_close;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// ===== rtl/trading_day_calendar_check_core.sv =====
// ----------------------------------------------------------------------------
// trading_day_calendar_check_core
// Pipeline: 13 stages; the computus chain sets the pipeline depth.
// Throughput: one item per cycle while the skid register is empty.
// An output skid register takes one result while the sink stalls.
// Reset clears the stage valid bits and skid, and loads 570/960 into the
// session window registers.
// ----------------------------------------------------------------------------
module trading_day_calendar_check_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tdcc_in_if.sink                         i_in,
    tdcc_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [tdcc_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [tdcc_pkg::CfgW-1:0]       i_cfg_data
);

    logic [tdcc_pkg::NumStages-1:0] r_vld;
    logic                           r_skid_vld;
    tdcc_pkg::t_result              r_skid;
    logic [tdcc_pkg::CfgW-1:0]      r_open;
    logic [tdcc_pkg::CfgW-1:0]      r_close;

    logic                           w_adv;
    tdcc_pkg::t_date_info           w_info;
    logic [tdcc_pkg::MonthW-1:0]    w_gf_month;
    logic [tdcc_pkg::DayW-1:0]      w_gf_day;
    tdcc_pkg::t_result              w_res;
    tdcc_pkg::t_result              w_out;

    // whole pipe moves unless the skid holds a result
    assign w_adv      = !r_skid_vld;
    assign i_in.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= tdcc_pkg::OpenReset;
            r_close <= tdcc_pkg::CloseReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tdcc_pkg::RegOpen:  r_open  <= i_cfg_data;
                tdcc_pkg::RegClose: r_close <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_skid_vld <= 1'b0;
        end else begin
            if (w_adv) begin
                r_vld <= {r_vld[tdcc_pkg::NumStages-2:0], i_in.valid};
            end
            if (r_skid_vld) begin
                if (o_out.ready) begin
                    r_skid_vld <= 1'b0;
                end
            end else if (r_vld[tdcc_pkg::LastStage] && !o_out.ready) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_vld) begin
            r_skid <= w_res;
        end
    end

    tdcc_date u_date (
        .i_clk    (i_clk),
        .i_adv    (w_adv),
        .i_year   (i_in.year),
        .i_month  (i_in.month),
        .i_day    (i_in.day_of_month),
        .i_minute (i_in.minute_of_day),
        .o_info   (w_info)
    );

    tdcc_easter u_easter (
        .i_clk      (i_clk),
        .i_adv      (w_adv),
        .i_year     (i_in.year),
        .o_gf_month (w_gf_month),
        .o_gf_day   (w_gf_day)
    );

    tdcc_classify u_classify (
        .i_clk      (i_clk),
        .i_adv      (w_adv),
        .i_info     (w_info),
        .i_gf_month (w_gf_month),
        .i_gf_day   (w_gf_day),
        .i_open     (r_open),
        .i_close    (r_close),
        .o_res      (w_res)
    );

    assign w_out                = r_skid_vld ? r_skid : w_res;
    assign o_out.valid          = r_skid_vld || r_vld[tdcc_pkg::LastStage];
    assign o_out.date_valid     = w_out.date_valid;
    assign o_out.day_of_week    = w_out.day_of_week;
    assign o_out.is_holiday     = w_out.is_holiday;
    assign o_out.is_trading_day = w_out.is_trading_day;
    assign o_out.market_open    = w_out.market_open;

    a_invalid_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.date_valid |-> o_out.day_of_week == 3'd0
            && !o_out.is_holiday && !o_out.is_trading_day && !o_out.market_open)
        else $error("invalid date result carries flags");

    a_open_trade: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.market_open |-> o_out.is_trading_day && !o_out.is_holiday)
        else $error("market open outside a trading day");

    a_trade_weekday: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.is_trading_day |-> o_out.day_of_week <= tdcc_pkg::DowFri)
        else $error("trading day on a weekend");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_vld[tdcc_pkg::LastStage] && !o_out.ready))
        else $error("skid filled without a stalled result");

endmodule
